[rtl/cvl_pkg.sv]
package cvl_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 6;
    localparam int COUNT_W       = 7;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_READ     = 2'd2,
        OP_CONTAINS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        op_t                        operation;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } cvl_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        logic                       found;
        logic [COUNT_W-1:0]         entry_count;
        status_t                    status;
    } cvl_out_t;

endpackage

[rtl/compacting_value_list.sv]
// Ordered list of up to DEPTH signed 32-bit entries in a single-port-write,
// single-port-read RAM. One word is taken at a time; each produces one result
// word. Insert passes through an execute and a finish state; read adds a wait
// for the RAM read. Remove and contains stream through the stored entries at
// one RAM read per cycle (contains stops early after a hit). A finished
// result waits in the output register while the next word is accepted.
// entry_count reports the low 7 bits of the internal count.
module compacting_value_list #(
    parameter int DEPTH = cvl_pkg::DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cvl_pkg::cvl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cvl_pkg::cvl_out_t m_data
);
    import cvl_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RDWAIT,
        S_FINISH
    } state_t;

    state_t             state_reg;
    cvl_in_t            item_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   keep_reg;
    logic               pend_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] rdv_reg;
    status_t            st_reg;
    cvl_out_t           out_reg;
    logic               m_valid_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic full;
    logic pos_ok;
    logic issue_ok;
    logic match;
    logic scan_end;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign pos_ok   = (CMP_W'(item_reg.position) < CMP_W'(cnt_reg));
    assign issue_ok = (idx_reg < cnt_reg) && !found_reg;
    assign match    = (rd_data == item_reg.value);
    assign scan_end = !pend_reg && !issue_ok;

    // Compaction writes at keep_reg, which never passes the index being read.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(item_reg.position);
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = item_reg.value;
        if (state_reg == S_SCAN) begin
            rd_en   = issue_ok;
            rd_addr = idx_reg[AW-1:0];
            wr_en   = (item_reg.operation == OP_REMOVE) && pend_reg && !match;
            wr_addr = keep_reg[AW-1:0];
            wr_data = rd_data;
        end else if (state_reg == S_EXEC) begin
            rd_en = (item_reg.operation == OP_READ) && pos_ok;
            wr_en = (item_reg.operation == OP_INSERT) && !full;
        end
    end

    cvl_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            if (m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    rdv_reg   <= '0;
                    found_reg <= 1'b0;
                    idx_reg   <= '0;
                    keep_reg  <= '0;
                    pend_reg  <= 1'b0;
                    case (item_reg.operation)
                        OP_INSERT: begin
                            if (full) begin
                                st_reg <= ST_FULL;
                            end else begin
                                st_reg  <= ST_OK;
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            state_reg <= S_FINISH;
                        end
                        OP_READ: begin
                            if (pos_ok) begin
                                st_reg    <= ST_OK;
                                state_reg <= S_RDWAIT;
                            end else begin
                                st_reg    <= ST_RANGE;
                                state_reg <= S_FINISH;
                            end
                        end
                        default: begin
                            st_reg    <= ST_OK;
                            state_reg <= S_SCAN;
                        end
                    endcase
                end
                S_SCAN: begin
                    pend_reg <= issue_ok;
                    if (issue_ok) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (pend_reg && !match) begin
                        keep_reg <= keep_reg + 1'b1;
                    end
                    if (pend_reg && match && item_reg.operation == OP_CONTAINS) begin
                        found_reg <= 1'b1;
                    end
                    if (scan_end) begin
                        if (item_reg.operation == OP_REMOVE) begin
                            cnt_reg <= keep_reg;
                        end
                        state_reg <= S_FINISH;
                    end
                end
                S_RDWAIT: begin
                    rdv_reg   <= rd_data;
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.read_value  <= rdv_reg;
                        out_reg.found       <= found_reg;
                        out_reg.entry_count <= COUNT_W'(cnt_reg);
                        out_reg.status      <= st_reg;
                        m_valid_reg         <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_keep_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> keep_reg <= idx_reg)
        else $error("compaction write index passed read index");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && item_reg.operation == OP_INSERT && !full)
        |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("insert did not grow the list");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.status == ST_RANGE && out_reg.read_value != '0))
        else $error("out of range read returned data");
`endif

endmodule

[rtl/cvl_store.sv]
module cvl_store #(
    parameter int DEPTH = cvl_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [cvl_pkg::VALUE_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [cvl_pkg::VALUE_W-1:0]  rd_data
);
    import cvl_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[verif/compacting_value_list_tb.sv]
module compacting_value_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cvl_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 80;
    localparam int POOL_SIZE   = 6;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cvl_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cvl_out_t m_data;

    // shadow copy of the list contents, in order
    logic signed [VALUE_W-1:0] shadow_entries[$];
    cvl_out_t                  expected_words[$];
    logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];

    int error_count = 0;
    int idle_cycles = 0;
    int ready_hold  = 0;
    bit quiet       = 1'b0;

    compacting_value_list dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // applies one word to the shadow list and returns the result it should produce
    function automatic cvl_out_t predict_list_op(input cvl_in_t w);
        cvl_out_t                  r;
        logic signed [VALUE_W-1:0] survivors[$];
        r = '0;
        r.status = ST_OK;
        case (w.operation)
            OP_INSERT: begin
                if (shadow_entries.size() >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                    shadow_entries.push_back(w.value);
            end
            OP_REMOVE: begin
                foreach (shadow_entries[i])
                    if (shadow_entries[i] !== w.value)
                        survivors.push_back(shadow_entries[i]);
                shadow_entries = survivors;
            end
            OP_READ: begin
                if (int'(w.position) < shadow_entries.size())
                    r.read_value = shadow_entries[w.position];
                else
                    r.status = ST_RANGE;
            end
            default: begin
                foreach (shadow_entries[i])
                    if (shadow_entries[i] === w.value)
                        r.found = 1'b1;
            end
        endcase
        r.entry_count = COUNT_W'(shadow_entries.size());
        return r;
    endfunction

    task automatic send_word(input op_t op, input logic signed [VALUE_W-1:0] v,
                             input logic [POS_W-1:0] pos);
        cvl_in_t w;
        w.operation = op;
        w.value     = v;
        w.position  = pos;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(predict_list_op(w));
    endtask

    task automatic refresh_pool();
        foreach (value_pool[i]) begin
            case ($urandom_range(0, 7))
                0:       value_pool[i] = 32'sh8000_0000;
                1:       value_pool[i] = 32'sh7fff_ffff;
                2:       value_pool[i] = -32'sd1;
                3:       value_pool[i] = 32'sd0;
                default: value_pool[i] = $urandom;
            endcase
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (shadow_entries.size() > 0 && $urandom_range(0, 3) != 0)
            return POS_W'($urandom_range(0, shadow_entries.size() - 1));
        return POS_W'($urandom_range(0, 63));
    endfunction

    // weights: insert below ins_pct, remove below rem_pct, read below rd_pct, else contains
    task automatic send_random_items(input int n, input int ins_pct, input int rem_pct,
                                     input int rd_pct);
        int roll;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                send_word(OP_INSERT, pick_value(), POS_W'($urandom));
            else if (roll < rem_pct)
                send_word(OP_REMOVE, pick_value(), POS_W'($urandom));
            else if (roll < rd_pct)
                send_word(OP_READ, POS_W'($urandom) == 0 ? $urandom : pick_value(),
                          pick_position());
            else
                send_word(OP_CONTAINS, pick_value(), POS_W'($urandom));
        end
    endtask

    task automatic test_empty_list();
        send_word(OP_READ, 32'sd0, 6'd0);
        send_word(OP_READ, -32'sd1, 6'd63);
        send_word(OP_CONTAINS, 32'sd0, 6'd0);
        send_word(OP_REMOVE, 32'sd0, 6'd0);
    endtask

    task automatic test_insert_read_extremes();
        send_word(OP_INSERT, 32'sh8000_0000, 6'd63);
        send_word(OP_INSERT, 32'sh7fff_ffff, 6'd0);
        send_word(OP_INSERT, 32'sd0, 6'd0);
        send_word(OP_INSERT, -32'sd1, 6'd0);
        send_word(OP_INSERT, 32'sd1, 6'd0);
        for (int p = 0; p < 5; p++)
            send_word(OP_READ, 32'sd0, POS_W'(p));
        send_word(OP_READ, 32'sd0, 6'd5);
        send_word(OP_READ, 32'sd0, 6'd63);
    endtask

    task automatic test_contains_remove();
        send_word(OP_CONTAINS, 32'sh8000_0000, 6'd0);
        send_word(OP_CONTAINS, 32'sd2, 6'd0);
        send_word(OP_INSERT, -32'sd1, 6'd0);
        // both copies go, later entries close up
        send_word(OP_REMOVE, -32'sd1, 6'd0);
        send_word(OP_READ, 32'sd0, 6'd2);
        send_word(OP_REMOVE, 32'sh7fff_fffe, 6'd0);
        send_word(OP_CONTAINS, -32'sd1, 6'd0);
    endtask

    task automatic test_fill_to_full();
        refresh_pool();
        while (shadow_entries.size() < LIST_DEPTH)
            send_word(OP_INSERT, value_pool[$urandom_range(0, 3)], POS_W'($urandom));
        repeat (3) send_word(OP_INSERT, pick_value(), 6'd0);
        send_word(OP_READ, 32'sd0, 6'd63);
        send_word(OP_READ, 32'sd0, 6'd0);
        send_word(OP_CONTAINS, shadow_entries[LIST_DEPTH - 1], 6'd0);
        while (shadow_entries.size() > 0)
            send_word(OP_REMOVE, shadow_entries[$urandom_range(0, shadow_entries.size() - 1)],
                      6'd0);
        send_word(OP_READ, 32'sd0, 6'd0);
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase % 2 == 0)
                refresh_pool();
            case (phase % 3)
                0:       send_random_items(140, 55, 65, 85);
                1:       send_random_items(140, 35, 50, 75);
                default: send_random_items(140, 20, 50, 75);
            endcase
        end
    endtask

    task automatic test_full_rate_tail();
        quiet = 1'b1;
        refresh_pool();
        send_random_items(90, 55, 62, 82);
        send_random_items(60, 30, 50, 75);
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 10);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cvl_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_data);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_data.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             want.read_value, m_data.read_value);
                    error_count++;
                end
                if (m_data.found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $time,
                             want.found, m_data.found);
                    error_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             want.entry_count, m_data.entry_count);
                    error_count++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_data.status);
                    error_count++;
                end
            end
        end
    end

    // no word moving on either side for too long means the block is hung
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_insert_read_extremes();
        test_contains_remove();
        test_fill_to_full();
        test_random_mix();
        test_full_rate_tail();

        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/cvl_pkg.sv
rtl/cvl_store.sv
rtl/compacting_value_list.sv
verif/compacting_value_list_tb.sv
